[src/sor_pkg.sv]
`default_nettype none
package sor_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLUMNS = 64;
    localparam int DATA_WIDTH  = 32;

    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int TOTAL_W     = $clog2(STORE_DEPTH + 1);
    localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CNT_W       = 7;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

    localparam logic ACTION_LOAD  = 1'b0;
    localparam logic ACTION_FETCH = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_FETCH = 2'd1,
        KIND_ERROR = 2'd2
    } sor_kind_t;

    typedef enum logic [3:0] {
        HEAD_RIGHT = 4'b0001,
        HEAD_DOWN  = 4'b0010,
        HEAD_LEFT  = 4'b0100,
        HEAD_UP    = 4'b1000
    } sor_heading_t;

    typedef struct packed {
        sor_kind_t               kind;
        logic [ADDR_W-1:0]       addr;
        logic [DATA_WIDTH-1:0]   data;
        logic                    last;
    } sor_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } sor_qstat_t;

    function automatic logic [CNT_W-1:0] clamp_count(
        input logic [CNT_W-1:0] value,
        input logic [CNT_W-1:0] limit
    );
        logic [CNT_W-1:0] result;
        if (value == '0) begin
            result = CNT_W'(1);
        end else if (value > limit) begin
            result = limit;
        end else begin
            result = value;
        end
        return result;
    endfunction

endpackage
`default_nettype wire

[src/sor_ram.sv]
`default_nettype none
module sor_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

[src/sor_front.sv]
`default_nettype none
module sor_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_accept,
    input  wire logic                              in_action,
    input  wire logic [sor_pkg::DATA_WIDTH-1:0]    in_element,
    input  wire logic                              cfg_write_en,
    input  wire logic [sor_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [sor_pkg::CNT_W-1:0]         cfg_data,
    output logic                                   push,
    output sor_pkg::sor_entry_t                    push_entry
);
    import sor_pkg::*;

    logic [CNT_W-1:0]   row_count_reg, row_count_next;
    logic [CNT_W-1:0]   column_count_reg, column_count_next;
    logic [TOTAL_W-1:0] loaded_count_reg, loaded_count_next;
    logic [TOTAL_W-1:0] emitted_count_reg, emitted_count_next;
    logic [ROW_W-1:0]   cursor_row_reg, cursor_row_next;
    logic [COL_W-1:0]   cursor_column_reg, cursor_column_next;
    sor_heading_t       heading_reg, heading_next;
    logic [ROW_W-1:0]   bound_top_reg, bound_top_next;
    logic [ROW_W-1:0]   bound_bottom_reg, bound_bottom_next;
    logic [COL_W-1:0]   bound_left_reg, bound_left_next;
    logic [COL_W-1:0]   bound_right_reg, bound_right_next;

    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] fetch_addr_wide;
    logic [TOTAL_W-1:0] emitted_inc;
    logic               walk_restart;
    logic               matrix_full;

    assign total           = TOTAL_W'(row_count_reg) * TOTAL_W'(column_count_reg);
    assign fetch_addr_wide = TOTAL_W'(cursor_row_reg) * TOTAL_W'(column_count_reg)
                           + TOTAL_W'(cursor_column_reg);
    assign emitted_inc     = emitted_count_reg + TOTAL_W'(1);
    assign matrix_full     = (loaded_count_reg >= total);

    always_comb begin
        row_count_next     = row_count_reg;
        column_count_next  = column_count_reg;
        loaded_count_next  = loaded_count_reg;
        emitted_count_next = emitted_count_reg;
        cursor_row_next    = cursor_row_reg;
        cursor_column_next = cursor_column_reg;
        heading_next       = heading_reg;
        bound_top_next     = bound_top_reg;
        bound_bottom_next  = bound_bottom_reg;
        bound_left_next    = bound_left_reg;
        bound_right_next   = bound_right_reg;
        walk_restart       = 1'b0;
        push               = 1'b0;
        push_entry.kind    = KIND_ERROR;
        push_entry.addr    = fetch_addr_wide[ADDR_W-1:0];
        push_entry.data    = in_element;
        push_entry.last    = 1'b0;

        if (cfg_write_en) begin
            if (cfg_index == CFG_ROW_COUNT) begin
                row_count_next    = clamp_count(cfg_data, CNT_W'(MAX_ROWS));
                loaded_count_next = '0;
                walk_restart      = 1'b1;
            end else if (cfg_index == CFG_COLUMN_COUNT) begin
                column_count_next = clamp_count(cfg_data, CNT_W'(MAX_COLUMNS));
                loaded_count_next = '0;
                walk_restart      = 1'b1;
            end
        end else if (in_accept) begin
            push = 1'b1;
            if (in_action == ACTION_LOAD) begin
                push_entry.kind = KIND_LOAD;
                if (matrix_full) begin
                    // full matrix: this load opens a new one
                    push_entry.addr   = '0;
                    loaded_count_next = TOTAL_W'(1);
                    walk_restart      = 1'b1;
                end else begin
                    push_entry.addr   = loaded_count_reg[ADDR_W-1:0];
                    loaded_count_next = loaded_count_reg + TOTAL_W'(1);
                end
            end else if (!matrix_full || emitted_count_reg >= total) begin
                push_entry.kind = KIND_ERROR;
            end else begin
                push_entry.kind    = KIND_FETCH;
                push_entry.last    = (emitted_inc == total);
                emitted_count_next = emitted_inc;
                unique case (heading_reg)
                    HEAD_RIGHT: begin
                        if (cursor_column_reg < bound_right_reg) begin
                            cursor_column_next = cursor_column_reg + COL_W'(1);
                        end else begin
                            bound_top_next  = bound_top_reg + ROW_W'(1);
                            heading_next    = HEAD_DOWN;
                            cursor_row_next = cursor_row_reg + ROW_W'(1);
                        end
                    end
                    HEAD_DOWN: begin
                        if (cursor_row_reg < bound_bottom_reg) begin
                            cursor_row_next = cursor_row_reg + ROW_W'(1);
                        end else begin
                            bound_right_next   = bound_right_reg - COL_W'(1);
                            heading_next       = HEAD_LEFT;
                            cursor_column_next = cursor_column_reg - COL_W'(1);
                        end
                    end
                    HEAD_LEFT: begin
                        if (cursor_column_reg > bound_left_reg) begin
                            cursor_column_next = cursor_column_reg - COL_W'(1);
                        end else begin
                            bound_bottom_next = bound_bottom_reg - ROW_W'(1);
                            heading_next      = HEAD_UP;
                            cursor_row_next   = cursor_row_reg - ROW_W'(1);
                        end
                    end
                    HEAD_UP: begin
                        if (cursor_row_reg > bound_top_reg) begin
                            cursor_row_next = cursor_row_reg - ROW_W'(1);
                        end else begin
                            bound_left_next    = bound_left_reg + COL_W'(1);
                            heading_next       = HEAD_RIGHT;
                            cursor_column_next = cursor_column_reg + COL_W'(1);
                        end
                    end
                    default: begin
                        heading_next = HEAD_RIGHT;
                    end
                endcase
            end
        end

        if (walk_restart) begin
            emitted_count_next = '0;
            cursor_row_next    = '0;
            cursor_column_next = '0;
            heading_next       = HEAD_RIGHT;
            bound_top_next     = '0;
            bound_left_next    = '0;
            bound_bottom_next  = ROW_W'(row_count_next - CNT_W'(1));
            bound_right_next   = COL_W'(column_count_next - CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg     <= CNT_W'(MAX_ROWS);
            column_count_reg  <= CNT_W'(MAX_COLUMNS);
            loaded_count_reg  <= '0;
            emitted_count_reg <= '0;
            cursor_row_reg    <= '0;
            cursor_column_reg <= '0;
            heading_reg       <= HEAD_RIGHT;
            bound_top_reg     <= '0;
            bound_bottom_reg  <= ROW_W'(MAX_ROWS - 1);
            bound_left_reg    <= '0;
            bound_right_reg   <= COL_W'(MAX_COLUMNS - 1);
        end else begin
            row_count_reg     <= row_count_next;
            column_count_reg  <= column_count_next;
            loaded_count_reg  <= loaded_count_next;
            emitted_count_reg <= emitted_count_next;
            cursor_row_reg    <= cursor_row_next;
            cursor_column_reg <= cursor_column_next;
            heading_reg       <= heading_next;
            bound_top_reg     <= bound_top_next;
            bound_bottom_reg  <= bound_bottom_next;
            bound_left_reg    <= bound_left_next;
            bound_right_reg   <= bound_right_next;
        end
    end

    a_emitted_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        emitted_count_reg <= total)
        else $error("emitted count beyond matrix size");

    a_loaded_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        loaded_count_reg <= total)
        else $error("loaded count beyond matrix size");

endmodule
`default_nettype wire

[src/sor_queue.sv]
`default_nettype none
module sor_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire sor_pkg::sor_entry_t  push_entry,
    input  wire logic                 pop,
    output sor_pkg::sor_entry_t       head_entry,
    output sor_pkg::sor_qstat_t       qstat
);
    import sor_pkg::*;

    sor_entry_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign do_push = push && !qstat.full;
    assign do_pop  = pop && !qstat.empty;

    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign head_entry  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !qstat.full)
        else $error("request pushed into full queue");

    a_pointers_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0 && count_reg != (QPTR_W + 1)'(QUEUE_DEPTH))
            |-> wr_ptr_reg != rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

[src/sor_back.sv]
`default_nettype none
module sor_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire sor_pkg::sor_entry_t             head_entry,
    input  wire sor_pkg::sor_qstat_t             qstat,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [sor_pkg::DATA_WIDTH-1:0]       m_tdata,
    output logic                                 m_tlast,
    output logic                                 m_tuser
);
    import sor_pkg::*;

    logic                  rd_valid_reg, rd_valid_next;
    logic                  rd_last_reg, rd_last_next;
    logic                  rd_error_reg, rd_error_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_user_reg, out_user_next;

    logic                  head_valid;
    logic                  head_is_load;
    logic                  rd_advance;
    logic                  ram_wr_en;
    logic                  ram_rd_en;
    logic [DATA_WIDTH-1:0] ram_rd_data;

    assign head_valid   = !qstat.empty;
    assign head_is_load = (head_entry.kind == KIND_LOAD);
    assign rd_advance   = rd_valid_reg && (!out_valid_reg || m_tready);
    assign pop          = head_valid && (head_is_load || !rd_valid_reg || rd_advance);
    assign ram_wr_en    = pop && head_is_load;
    assign ram_rd_en    = pop && (head_entry.kind == KIND_FETCH);

    sor_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (head_entry.addr),
        .wr_data (head_entry.data),
        .rd_en   (ram_rd_en),
        .rd_addr (head_entry.addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        rd_valid_next  = rd_valid_reg;
        rd_last_next   = rd_last_reg;
        rd_error_next  = rd_error_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;

        if (rd_advance) begin
            rd_valid_next  = 1'b0;
            out_valid_next = 1'b1;
            out_data_next  = rd_error_reg ? '0 : ram_rd_data;
            out_last_next  = rd_last_reg && !rd_error_reg;
            out_user_next  = rd_error_reg ? STATUS_ERROR : STATUS_OK;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        if (pop && !head_is_load) begin
            rd_valid_next = 1'b1;
            rd_last_next  = head_entry.last;
            rd_error_next = (head_entry.kind != KIND_FETCH);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
        rd_last_reg  <= rd_last_next;
        rd_error_reg <= rd_error_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    a_error_result_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STATUS_ERROR) |-> (m_tdata == '0 && !m_tlast))
        else $error("error result carries data or last flag");

endmodule
`default_nettype wire

[src/spiral_order_readout.sv]
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata element_in, s_tuser action
// m_*       out  m_tvalid/m_tready  m_tdata element_out, m_tlast is_last, m_tuser status
// cfg_*     in   cfg_write_en       cfg_index register, cfg_data value
//
// Sustained rate is one request per cycle, loads and fetches alike, unless the output stalls.
// A fetch result passes through the queue, then the store read, then the output register.
// The four-entry queue between front and back sets how long input keeps flowing under stall.
// Reset (aresetn low, synchronous) sets 64 x 64, empty matrix, walk at the top-left corner.
// The matrix store has no reset; a fetch before a complete load returns an error status.
`default_nettype none
module spiral_order_readout (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    input  wire logic signed [sor_pkg::DATA_WIDTH-1:0]   s_tdata,  // [31:0] element_in
    input  wire logic                                    s_tuser,  // [0] action
    output logic                                         m_tvalid,
    input  wire logic                                    m_tready,
    output logic signed [sor_pkg::DATA_WIDTH-1:0]        m_tdata,  // [31:0] element_out
    output logic                                         m_tlast,
    output logic                                         m_tuser,  // [0] status
    input  wire logic                                    cfg_write_en,
    input  wire logic [sor_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  wire logic [sor_pkg::CNT_W-1:0]               cfg_data
);
    import sor_pkg::*;

    logic                  in_accept;
    logic                  push;
    logic                  pop;
    sor_entry_t            push_entry;
    sor_entry_t            head_entry;
    sor_qstat_t            qstat;
    logic [DATA_WIDTH-1:0] out_data;

    assign s_tready  = !qstat.full;
    assign in_accept = s_tvalid && s_tready;

    sor_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (in_accept),
        .in_action    (s_tuser),
        .in_element   (s_tdata),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .push_entry   (push_entry)
    );

    sor_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .qstat      (qstat)
    );

    sor_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_entry (head_entry),
        .qstat      (qstat),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (out_data),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    assign m_tdata = out_data;

endmodule
`default_nettype wire

[bench/spiral_order_readout_test.sv]
`timescale 1ns / 100ps
module spiral_order_readout_test;
    import sor_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LOAD_SETTLE  = 8;
    localparam int RANDOM_ITEMS = 380;
    localparam int CALM_TAIL    = 80;
    localparam int REPORT_LIMIT = 10;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] element;
        logic                  last;
        logic                  status;
    } spiral_word_t;

    logic                          aclk         = 1'b0;
    logic                          aresetn      = 1'b0;
    logic                          s_tvalid     = 1'b0;
    logic                          s_tready;
    logic signed [DATA_WIDTH-1:0]  s_tdata      = '0;
    logic                          s_tuser      = ACTION_LOAD;
    logic                          m_tvalid;
    logic                          m_tready     = 1'b0;
    logic signed [DATA_WIDTH-1:0]  m_tdata;
    logic                          m_tlast;
    logic                          m_tuser;
    logic                          cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0]        cfg_index    = '0;
    logic [CNT_W-1:0]              cfg_data     = '0;

    spiral_order_readout u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 aclk = ~aclk;

    // spiral walk predictor
    logic [DATA_WIDTH-1:0] grid_words [STORE_DEPTH];
    int                    rows_used;
    int                    cols_used;
    int                    words_loaded;
    int                    words_emitted;
    int                    at_row;
    int                    at_col;
    int                    lim_top;
    int                    lim_bottom;
    int                    lim_left;
    int                    lim_right;
    sor_heading_t          walk_dir;
    spiral_word_t          spiral_due [$];

    int  fault_count     = 0;
    int  results_checked = 0;
    int  items_sent      = 0;
    int  loads_sent      = 0;
    int  fetches_sent    = 0;
    int  cfg_writes      = 0;
    int  cycle_count     = 0;
    bit  src_gaps        = 1'b1;
    bit  sink_stalls     = 1'b1;
    spiral_word_t due_word;

    function automatic int saturate_dim(input logic [CNT_W-1:0] raw, input int ceiling);
        if (raw == '0) return 1;
        if (int'(raw) > ceiling) return ceiling;
        return int'(raw);
    endfunction

    function automatic void rewind_walk();
        words_emitted = 0;
        at_row        = 0;
        at_col        = 0;
        walk_dir      = HEAD_RIGHT;
        lim_top       = 0;
        lim_bottom    = rows_used - 1;
        lim_left      = 0;
        lim_right     = cols_used - 1;
    endfunction

    function automatic void step_cursor();
        case (walk_dir)
            HEAD_RIGHT: begin
                if (at_col < lim_right) begin
                    at_col++;
                end else begin
                    lim_top++;
                    walk_dir = HEAD_DOWN;
                    at_row++;
                end
            end
            HEAD_DOWN: begin
                if (at_row < lim_bottom) begin
                    at_row++;
                end else begin
                    lim_right--;
                    walk_dir = HEAD_LEFT;
                    at_col--;
                end
            end
            HEAD_LEFT: begin
                if (at_col > lim_left) begin
                    at_col--;
                end else begin
                    lim_bottom--;
                    walk_dir = HEAD_UP;
                    at_row--;
                end
            end
            default: begin
                if (at_row > lim_top) begin
                    at_row--;
                end else begin
                    lim_left++;
                    walk_dir = HEAD_RIGHT;
                    at_col++;
                end
            end
        endcase
    endfunction

    function automatic void spiral_step(input logic act, input logic [DATA_WIDTH-1:0] value);
        int           total;
        spiral_word_t word;
        total = rows_used * cols_used;
        word  = '0;
        if (act == ACTION_LOAD) begin
            if (words_loaded >= total) begin
                words_loaded = 0;
                rewind_walk();
            end
            grid_words[words_loaded] = value;
            words_loaded++;
        end else if (words_loaded < total || words_emitted >= total) begin
            word.status = STATUS_ERROR;
            spiral_due = {spiral_due, word};
        end else begin
            word.element = grid_words[at_row * cols_used + at_col];
            words_emitted++;
            word.last   = (words_emitted == total);
            word.status = STATUS_OK;
            spiral_due = {spiral_due, word};
            step_cursor();
        end
    endfunction

    function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                           input logic [CNT_W-1:0] raw);
        case (idx)
            CFG_ROW_COUNT:    rows_used = saturate_dim(raw, MAX_ROWS);
            CFG_COLUMN_COUNT: cols_used = saturate_dim(raw, MAX_COLUMNS);
            default:          return;
        endcase
        words_loaded = 0;
        rewind_walk();
    endfunction

    function automatic void log_fault(input string note);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) $display("%s", note);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_element();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(DATA_WIDTH-1){1'b0}}};
            1:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return DATA_WIDTH'($urandom());
        endcase
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (spiral_due.size() == 0) begin
                log_fault($sformatf("unexpected result: data %h last %b status %b",
                                    m_tdata, m_tlast, m_tuser));
            end else begin
                due_word = spiral_due.pop_front();
                if (m_tdata !== due_word.element || m_tlast !== due_word.last ||
                    m_tuser !== due_word.status) begin
                    log_fault($sformatf({"result %0d: want data %h last %b status %b,",
                                         " got data %h last %b status %b"},
                                        results_checked, due_word.element, due_word.last,
                                        due_word.status, m_tdata, m_tlast, m_tuser));
                end
            end
        end
    end

    // result side back-pressure
    initial begin : sink_driver
        forever begin
            @(posedge aclk);
            if (sink_stalls && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    task automatic push_request(input logic act, input logic [DATA_WIDTH-1:0] value);
        if (src_gaps && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        spiral_step(act, value);
        items_sent++;
        if (act == ACTION_FETCH) fetches_sent++;
        else loads_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (spiral_due.size() != 0) @(posedge aclk);
        // loads leave nothing to wait on, give them time to land
        repeat (LOAD_SETTLE) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CNT_W-1:0] raw);
        wait_drained();
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= raw;
        @(posedge aclk);
        apply_register(idx, raw);
        cfg_write_en <= 1'b0;
        repeat (2) @(posedge aclk);
        cfg_writes++;
    endtask

    task automatic set_shape(input logic [CNT_W-1:0] raw_rows, input logic [CNT_W-1:0] raw_cols);
        write_register(CFG_ROW_COUNT, raw_rows);
        write_register(CFG_COLUMN_COUNT, raw_cols);
    endtask

    // loads just enough to complete the matrix, or a whole new one when full
    task automatic fill_matrix();
        int total;
        int count;
        total = rows_used * cols_used;
        count = (words_loaded >= total) ? total : total - words_loaded;
        repeat (count) push_request(ACTION_LOAD, pick_element());
    endtask

    task automatic fetch_run(input int count);
        repeat (count) push_request(ACTION_FETCH, DATA_WIDTH'($urandom()));
    endtask

    task automatic test_fetch_before_load();
        fetch_run(1);
        push_request(ACTION_LOAD, pick_element());
        fetch_run(1);
    endtask

    task automatic test_single_element();
        set_shape('0, '0);
        push_request(ACTION_LOAD, {1'b0, {(DATA_WIDTH-1){1'b1}}});
        fetch_run(2);
        push_request(ACTION_LOAD, {1'b1, {(DATA_WIDTH-1){1'b0}}});
        fetch_run(1);
        push_request(ACTION_LOAD, '0);
        push_request(ACTION_LOAD, '1);
        fetch_run(2);
    endtask

    task automatic test_small_spiral();
        set_shape(7'd2, 7'd3);
        fill_matrix();
        fetch_run(3);
        wait_drained();
        fetch_run(4);
    endtask

    task automatic test_register_limits();
        set_shape(7'd127, 7'd1);
        fill_matrix();
        fetch_run(65);
        set_shape(7'd1, 7'd100);
        repeat (30) push_request(ACTION_LOAD, pick_element());
        // writes past the register list must not disturb a load in progress
        write_register(CFG_SPARE_2, 7'd5);
        write_register(CFG_SPARE_3, '0);
        fill_matrix();
        fetch_run(65);
    endtask

    task automatic test_random_walks();
        int               first_item;
        int               total;
        int               pick;
        logic [CNT_W-1:0] raw_rows;
        logic [CNT_W-1:0] raw_cols;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            if (items_sent - first_item >= RANDOM_ITEMS - CALM_TAIL) begin
                src_gaps    = 1'b0;
                sink_stalls = 1'b0;
            end else begin
                src_gaps    = ($urandom_range(0, 3) != 0);
                sink_stalls = ($urandom_range(0, 3) != 0);
            end
            if (items_sent == first_item || $urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0: begin
                        raw_rows = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(64, 127))
                                                               : CNT_W'($urandom_range(6, 16));
                        raw_cols = CNT_W'($urandom_range(0, 2));
                    end
                    1: begin
                        raw_rows = CNT_W'($urandom_range(0, 2));
                        raw_cols = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(64, 127))
                                                               : CNT_W'($urandom_range(6, 16));
                    end
                    default: begin
                        raw_rows = CNT_W'($urandom_range(0, 5));
                        raw_cols = CNT_W'($urandom_range(0, 5));
                    end
                endcase
                set_shape(raw_rows, raw_cols);
                if ($urandom_range(0, 7) == 0) begin
                    write_register($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                                   CNT_W'($urandom()));
                end
            end
            total = rows_used * cols_used;
            pick  = $urandom_range(0, 9);
            if (pick <= 5) begin
                fill_matrix();
                fetch_run(total + $urandom_range(0, 1));
            end else if (pick == 6) begin
                repeat ($urandom_range(3, 12)) begin
                    push_request(1'($urandom_range(0, 1)), pick_element());
                end
            end else if (pick == 7) begin
                repeat ($urandom_range(1, total)) push_request(ACTION_LOAD, pick_element());
                fetch_run(1);
                fill_matrix();
                fetch_run($urandom_range(0, total));
            end else if (pick == 8) begin
                // reload in the middle of a walk
                fill_matrix();
                fetch_run($urandom_range(1, total));
                fill_matrix();
                fetch_run(total);
            end else begin
                fill_matrix();
                fetch_run(total / 2);
                wait_drained();
                fetch_run(total - total / 2 + 1);
            end
        end
    endtask

    initial begin
        rows_used    = MAX_ROWS;
        cols_used    = MAX_COLUMNS;
        words_loaded = 0;
        rewind_walk();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_fetch_before_load();
        test_single_element();
        test_small_spiral();
        test_register_limits();
        test_random_walks();
        wait_drained();

        $display("spiral readout: %0d loads, %0d fetches, %0d results compared, %0d reg writes",
                 loads_sent, fetches_sent, results_checked, cfg_writes);
        $display("shapes 1x1 to 64-wide/tall, early/late fetches, reloads, stalls; %0d faults",
                 fault_count);
        if (fault_count == 0 && spiral_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
